@@ hw/rtl/hric_pkg.sv @@
// Shared types and constants for the HVAC relay interlock controller.
// Used by hric_core, hric_div, the top level and the port checker.
package hric_pkg;

  localparam int unsigned LockW  = 24;
  localparam int unsigned StampW = 32;
  localparam int unsigned SecW   = 15;
  localparam int unsigned CfgIdxW = 4;

  localparam logic [LockW-1:0]  STARTUP_WAIT_MS   = 24'd60000;
  localparam logic [LockW-1:0]  COOL_DELAY_RESET  = 24'd300000;
  localparam logic [LockW-1:0]  HEAT_DELAY_RESET  = 24'd120000;
  localparam logic [StampW-1:0] HEAT_STAMP_RESET  = 32'd1;

  // floor(2^32 / 1000): reciprocal for the ms to seconds conversion
  localparam logic [22:0] MS_RECIP   = 23'd4294967;
  localparam int unsigned RecipShift = 32;
  localparam logic [9:0]  MS_PER_SEC = 10'd1000;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ON      = 2'd1,
    OP_OFF     = 2'd2,
    OP_ALL_OFF = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RLY_HEAT = 2'd0,
    RLY_COOL = 2'd1,
    RLY_FAN  = 2'd2,
    RLY_NONE = 2'd3
  } relay_e;

  typedef enum logic [2:0] {
    ACT_OFF  = 3'd0,
    ACT_WAIT = 3'd1,
    ACT_HEAT = 3'd2,
    ACT_COOL = 3'd3,
    ACT_FAN  = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COOL_DELAY = 4'd0,
    CFG_HEAT_DELAY = 4'd1
  } cfg_reg_e;

  // State seen after one command word
  typedef struct packed {
    logic              accepted;
    logic              heat_on;
    logic              cool_on;
    logic              fan_on;
    action_e           action;
    logic [LockW-1:0]  lock_ms;
    logic [StampW-1:0] last_on;
  } snap_t;

endpackage

@@ hw/rtl/hric_core.sv @@
// Relay state, lockout countdown, ms clock and switch-on timestamps.
// Computes the state after each command word; uses hric_pkg.
module hric_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [1:0]                   opcode_i,
  input  logic [1:0]                   relay_type_i,
  input  logic                         cfg_we_i,
  input  logic [hric_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hric_pkg::LockW-1:0]   cfg_data_i,
  output hric_pkg::snap_t              snap_o
);

  logic                          heat_q, heat_d;
  logic                          cool_q, cool_d;
  logic                          fan_q, fan_d;
  logic [hric_pkg::LockW-1:0]    lock_q, lock_d;
  logic [hric_pkg::StampW-1:0]   now_q, now_d;
  logic [hric_pkg::StampW-1:0]   stamp_q [3];
  logic [hric_pkg::StampW-1:0]   stamp_d [3];
  logic [hric_pkg::LockW-1:0]    cool_dly_q;
  logic [hric_pkg::LockW-1:0]    heat_dly_q;
  logic                          acc;
  hric_pkg::action_e             act;
  logic [hric_pkg::StampW-1:0]   last_on;

  // Apply one command word to the current state
  always_comb begin
    heat_d     = heat_q;
    cool_d     = cool_q;
    fan_d      = fan_q;
    lock_d     = lock_q;
    now_d      = now_q;
    stamp_d[0] = stamp_q[0];
    stamp_d[1] = stamp_q[1];
    stamp_d[2] = stamp_q[2];
    acc        = 1'b1;
    unique case (hric_pkg::op_e'(opcode_i))
      hric_pkg::OP_TICK: begin
        now_d = now_q + 32'd1;
        if (lock_q != '0) begin
          lock_d = lock_q - 24'd1;
        end
      end
      hric_pkg::OP_ON: begin
        unique case (hric_pkg::relay_e'(relay_type_i))
          hric_pkg::RLY_HEAT: begin
            if (!heat_q) begin
              if (lock_q != '0) begin
                acc = 1'b0;
              end else if (cool_q) begin
                // interlock: only drop cooling and its fan, and start the cooling lockout
                cool_d = 1'b0;
                fan_d  = 1'b0;
                lock_d = cool_dly_q;
                acc    = 1'b0;
              end else begin
                fan_d      = 1'b0;
                heat_d     = 1'b1;
                stamp_d[0] = now_q;
              end
            end
          end
          hric_pkg::RLY_COOL: begin
            if (!cool_q) begin
              if (lock_q != '0) begin
                acc = 1'b0;
              end else if (heat_q) begin
                heat_d = 1'b0;
                lock_d = heat_dly_q;
                acc    = 1'b0;
              end else begin
                cool_d     = 1'b1;
                fan_d      = 1'b1;
                stamp_d[1] = now_q;
                stamp_d[2] = now_q;
              end
            end
          end
          hric_pkg::RLY_FAN: begin
            if (!fan_q) begin
              if (lock_q != '0) begin
                acc = 1'b0;
              end else begin
                fan_d      = 1'b1;
                stamp_d[2] = now_q;
              end
            end
          end
          default: begin
            acc = 1'b0;
          end
        endcase
      end
      hric_pkg::OP_OFF: begin
        unique case (hric_pkg::relay_e'(relay_type_i))
          hric_pkg::RLY_HEAT: begin
            if (heat_q) begin
              heat_d = 1'b0;
              lock_d = heat_dly_q;
            end
          end
          hric_pkg::RLY_COOL: begin
            if (cool_q) begin
              cool_d = 1'b0;
              fan_d  = 1'b0;
              lock_d = cool_dly_q;
            end
          end
          hric_pkg::RLY_FAN: begin
            // fan off while cooling runs takes cooling down with it
            if (fan_q) begin
              fan_d = 1'b0;
              if (cool_q) begin
                cool_d = 1'b0;
                lock_d = cool_dly_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
      hric_pkg::OP_ALL_OFF: begin
        // heat, then cooling; the later lockout wins
        heat_d = 1'b0;
        cool_d = 1'b0;
        fan_d  = 1'b0;
        if (cool_q) begin
          lock_d = cool_dly_q;
        end else if (heat_q) begin
          lock_d = heat_dly_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Summarize the new state
  always_comb begin
    if (lock_d != '0) begin
      act = hric_pkg::ACT_WAIT;
    end else if (heat_d) begin
      act = hric_pkg::ACT_HEAT;
    end else if (cool_d) begin
      act = hric_pkg::ACT_COOL;
    end else if (fan_d) begin
      act = hric_pkg::ACT_FAN;
    end else begin
      act = hric_pkg::ACT_OFF;
    end
  end

  always_comb begin
    unique case (hric_pkg::relay_e'(relay_type_i))
      hric_pkg::RLY_HEAT: last_on = stamp_d[0];
      hric_pkg::RLY_COOL: last_on = stamp_d[1];
      hric_pkg::RLY_FAN:  last_on = stamp_d[2];
      default:            last_on = '0;
    endcase
  end

  assign snap_o = '{accepted: acc, heat_on: heat_d, cool_on: cool_d, fan_on: fan_d,
                    action: act, lock_ms: lock_d, last_on: last_on};

  // Advance state on each command word taken, whether accepted or refused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q     <= 1'b0;
      cool_q     <= 1'b0;
      fan_q      <= 1'b0;
      lock_q     <= hric_pkg::STARTUP_WAIT_MS;
      now_q      <= '0;
      stamp_q[0] <= hric_pkg::HEAT_STAMP_RESET;
      stamp_q[1] <= '0;
      stamp_q[2] <= '0;
    end else if (fire_i) begin
      heat_q     <= heat_d;
      cool_q     <= cool_d;
      fan_q      <= fan_d;
      lock_q     <= lock_d;
      now_q      <= now_d;
      stamp_q[0] <= stamp_d[0];
      stamp_q[1] <= stamp_d[1];
      stamp_q[2] <= stamp_d[2];
    end
  end

  // Lockout length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cool_dly_q <= hric_pkg::COOL_DELAY_RESET;
      heat_dly_q <= hric_pkg::HEAT_DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hric_pkg::CFG_COOL_DELAY: cool_dly_q <= cfg_data_i;
        hric_pkg::CFG_HEAT_DELAY: heat_dly_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/hric_div.sv @@
// Two-stage result path: reciprocal multiply of the lockout ms, then the
// divide-by-1000 correction into the output register. Uses hric_pkg.
module hric_div (
  input  logic                         clk_i,
  input  logic                         load_b_i,
  input  logic                         load_c_i,
  input  hric_pkg::snap_t              snap_i,
  output hric_pkg::snap_t              res_o,
  output logic [hric_pkg::SecW-1:0]    secs_o
);

  localparam int unsigned ProdW = hric_pkg::LockW + 23;

  logic [ProdW-1:0]              prod;
  logic [hric_pkg::SecW-1:0]     q0_q;
  hric_pkg::snap_t               snap_q;
  hric_pkg::snap_t               res_q;
  logic [hric_pkg::SecW-1:0]     secs_q;
  logic [hric_pkg::LockW+1:0]    back;
  logic [hric_pkg::LockW+1:0]    rem;
  logic [hric_pkg::SecW-1:0]     secs_d;

  // Estimate: never above the true quotient, at most one below
  assign prod = ProdW'(snap_i.lock_ms) * ProdW'(hric_pkg::MS_RECIP);

  always_ff @(posedge clk_i) begin
    if (load_b_i) begin
      snap_q <= snap_i;
      q0_q   <= prod[hric_pkg::RecipShift +: hric_pkg::SecW];
    end
  end

  // Fix up the estimate with one compare
  assign back   = (hric_pkg::LockW+2)'(q0_q) * (hric_pkg::LockW+2)'(hric_pkg::MS_PER_SEC);
  assign rem    = (hric_pkg::LockW+2)'(snap_q.lock_ms) - back;
  assign secs_d = (rem >= (hric_pkg::LockW+2)'(hric_pkg::MS_PER_SEC)) ? q0_q + 15'd1 : q0_q;

  always_ff @(posedge clk_i) begin
    if (load_c_i) begin
      res_q  <= snap_q;
      secs_q <= secs_d;
    end
  end

  assign res_o  = res_q;
  assign secs_o = secs_q;

endmodule

@@ hw/rtl/hvac_relay_interlock_controller.sv @@
// Top level of the HVAC relay interlock controller: handshakes and the
// two-stage result pipeline. Uses hric_pkg, hric_core and hric_div.
//
// Usage:
//   Command channel: in_valid_i / in_stall_o carry opcode_i (tick, on, off,
//   all off) and relay_type_i. A word is taken when valid is high and stall
//   is low. Every word gives exactly one result word on the result channel
//   out_valid_o / out_stall_i, in order.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i (0 cooling
//   delay, 1 heat delay) and cfg_data_i; ready is always high. Write only
//   while no command is in flight.
//   A result word passes the middle register and then the output register
//   before it is valid; one word per cycle is sustained while the receiver
//   does not stall. The accepting cycle does the state update and the
//   reciprocal multiply of the lockout ms; the middle stage then corrects
//   the seconds quotient.
//   When the receiver stalls, the result word holds; the middle stage still
//   takes one more word before in_stall_o rises.
//   Reset clears all relays, loads the 60 s startup lockout and the
//   default delays, and empties the pipeline.
module hvac_relay_interlock_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [1:0]                   relay_type_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hric_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [hric_pkg::LockW-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         accepted_o,
  output logic                         heat_on_o,
  output logic                         cool_on_o,
  output logic                         fan_on_o,
  output logic [2:0]                   action_o,
  output logic [hric_pkg::SecW-1:0]    wait_seconds_left_o,
  output logic [hric_pkg::StampW-1:0]  last_on_time_o
);

  logic            vb_q, vb_d;
  logic            vc_q, vc_d;
  logic            rdy_b, rdy_c;
  logic            fire;
  hric_pkg::snap_t snap;
  hric_pkg::snap_t res;

  // Ready chain back from the output register
  assign rdy_c      = !vc_q || !out_stall_i;
  assign rdy_b      = !vb_q || rdy_c;
  assign fire       = in_valid_i && rdy_b;
  assign in_stall_o = !rdy_b;
  assign vb_d       = rdy_b ? in_valid_i : vb_q;
  assign vc_d       = rdy_c ? vb_q : vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      vb_q <= vb_d;
      vc_q <= vc_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  hric_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .opcode_i     (opcode_i),
    .relay_type_i (relay_type_i),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .snap_o       (snap)
  );

  hric_div u_div (
    .clk_i    (clk_i),
    .load_b_i (fire),
    .load_c_i (rdy_c && vb_q),
    .snap_i   (snap),
    .res_o    (res),
    .secs_o   (wait_seconds_left_o)
  );

  // Drive the result word
  assign out_valid_o    = vc_q;
  assign accepted_o     = res.accepted;
  assign heat_on_o      = res.heat_on;
  assign cool_on_o      = res.cool_on;
  assign fan_on_o       = res.fan_on;
  assign action_o       = res.action;
  assign last_on_time_o = res.last_on;

endmodule

@@ hw/rtl/hric_checker.sv @@
// Port-level checks for the HVAC relay interlock controller.
// Uses hric_pkg; bound to the top level below.
module hric_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         heat_on_o,
  input logic                         cool_on_o,
  input logic                         fan_on_o,
  input logic [2:0]                   action_o,
  input logic [hric_pkg::SecW-1:0]    wait_seconds_left_o,
  input logic [hric_pkg::StampW-1:0]  last_on_time_o
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(last_on_time_o)
      && $stable(wait_seconds_left_o) && $stable(action_o))
    else $error("result word changed under stall");

  // Heat and cooling never run together
  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(heat_on_o && cool_on_o))
    else $error("heat and cooling both on");

  // Cooling always carries the fan
  a_cool_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cool_on_o |-> fan_on_o)
    else $error("cooling on without fan");

  // Seconds left implies waiting
  a_wait_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (wait_seconds_left_o != '0) |-> action_o == hric_pkg::ACT_WAIT)
    else $error("lockout seconds shown without waiting action");

endmodule

bind hvac_relay_interlock_controller hric_checker u_hric_checker (.*);

@@ test/tb.sv @@
// Self-checking testbench for hvac_relay_interlock_controller: random and
// directed command words against a cycle-free predictor of the relay rules.
// Depends on hric_pkg and the controller RTL only.
module tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned MaxReports = 100;
  localparam int unsigned DrainWait  = 4;
  localparam logic [hric_pkg::CfgIdxW-1:0] CfgIdxUnused = {hric_pkg::CfgIdxW{1'b1}};
  localparam logic [hric_pkg::LockW-1:0]   DelayMax     = {hric_pkg::LockW{1'b1}};

  // Status word expected for each command word
  typedef struct {
    logic                        accepted;
    logic                        heat_on;
    logic                        cool_on;
    logic                        fan_on;
    hric_pkg::action_e           action;
    logic [hric_pkg::SecW-1:0]   secs;
    logic [hric_pkg::StampW-1:0] last_on;
  } status_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  hric_pkg::op_e                 opcode;
  hric_pkg::relay_e              relay_type;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hric_pkg::CfgIdxW-1:0]  cfg_index;
  logic [hric_pkg::LockW-1:0]    cfg_data;
  logic                          out_valid;
  logic                          out_stall;
  logic                          accepted;
  logic                          heat_on;
  logic                          cool_on;
  logic                          fan_on;
  logic [2:0]                    action;
  logic [hric_pkg::SecW-1:0]     wait_secs;
  logic [hric_pkg::StampW-1:0]   last_on_time;

  // Predicted controller state
  logic [2:0]                    relay_on;
  logic [hric_pkg::LockW-1:0]    lock_ms;
  logic [hric_pkg::StampW-1:0]   now_ms;
  logic [hric_pkg::StampW-1:0]   on_stamp [3];
  logic [hric_pkg::LockW-1:0]    cool_delay;
  logic [hric_pkg::LockW-1:0]    heat_delay;

  status_t             pending_status [$];
  int unsigned         mismatches;
  int unsigned         src_idle_pct;
  int unsigned         snk_idle_pct;
  int unsigned         stall_hold;
  int unsigned         cycles;

  hvac_relay_interlock_controller dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .opcode_i            (opcode),
    .relay_type_i        (relay_type),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .accepted_o          (accepted),
    .heat_on_o           (heat_on),
    .cool_on_o           (cool_on),
    .fan_on_o            (fan_on),
    .action_o            (action),
    .wait_seconds_left_o (wait_secs),
    .last_on_time_o      (last_on_time)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic void energize(hric_pkg::relay_e r);
    relay_on[r] = 1'b1;
    on_stamp[r] = now_ms;
  endfunction

  // Drop one relay and start the lockout that belongs to it, if any
  function automatic void relay_drop(hric_pkg::relay_e r);
    if (!relay_on[r]) return;
    case (r)
      hric_pkg::RLY_HEAT: begin
        relay_on[hric_pkg::RLY_HEAT] = 1'b0;
        lock_ms = heat_delay;
      end
      hric_pkg::RLY_COOL: begin
        relay_on[hric_pkg::RLY_COOL] = 1'b0;
        relay_on[hric_pkg::RLY_FAN]  = 1'b0;
        lock_ms = cool_delay;
      end
      default: begin
        // fan off while cooling runs takes cooling down with it
        if (relay_on[hric_pkg::RLY_COOL]) lock_ms = cool_delay;
        relay_on[hric_pkg::RLY_COOL] = 1'b0;
        relay_on[hric_pkg::RLY_FAN]  = 1'b0;
      end
    endcase
  endfunction

  function automatic logic relay_raise(hric_pkg::relay_e r);
    if (relay_on[r]) return 1'b1;
    if (lock_ms != '0) return 1'b0;
    case (r)
      hric_pkg::RLY_HEAT: begin
        if (relay_on[hric_pkg::RLY_COOL]) begin
          relay_drop(hric_pkg::RLY_COOL);
          return 1'b0;
        end
        if (relay_on[hric_pkg::RLY_FAN]) relay_drop(hric_pkg::RLY_FAN);
        energize(hric_pkg::RLY_HEAT);
      end
      hric_pkg::RLY_COOL: begin
        if (relay_on[hric_pkg::RLY_HEAT]) begin
          relay_drop(hric_pkg::RLY_HEAT);
          return 1'b0;
        end
        energize(hric_pkg::RLY_COOL);
        energize(hric_pkg::RLY_FAN);
      end
      default: energize(hric_pkg::RLY_FAN);
    endcase
    return 1'b1;
  endfunction

  // Apply one command word and queue the status word it must produce
  function automatic void predict_status(hric_pkg::op_e op, hric_pkg::relay_e rly);
    status_t s;
    logic    ok;
    ok = 1'b1;
    case (op)
      hric_pkg::OP_TICK: begin
        now_ms = now_ms + 1'b1;
        if (lock_ms != '0) lock_ms = lock_ms - 1'b1;
      end
      hric_pkg::OP_ON:  ok = (rly == hric_pkg::RLY_NONE) ? 1'b0 : relay_raise(rly);
      hric_pkg::OP_OFF: if (rly != hric_pkg::RLY_NONE) relay_drop(rly);
      default: begin
        relay_drop(hric_pkg::RLY_HEAT);
        relay_drop(hric_pkg::RLY_COOL);
        relay_drop(hric_pkg::RLY_FAN);
      end
    endcase
    s.accepted = ok;
    s.heat_on  = relay_on[hric_pkg::RLY_HEAT];
    s.cool_on  = relay_on[hric_pkg::RLY_COOL];
    s.fan_on   = relay_on[hric_pkg::RLY_FAN];
    if (lock_ms != '0)                         s.action = hric_pkg::ACT_WAIT;
    else if (relay_on[hric_pkg::RLY_HEAT])     s.action = hric_pkg::ACT_HEAT;
    else if (relay_on[hric_pkg::RLY_COOL])     s.action = hric_pkg::ACT_COOL;
    else if (relay_on[hric_pkg::RLY_FAN])      s.action = hric_pkg::ACT_FAN;
    else                                       s.action = hric_pkg::ACT_OFF;
    s.secs    = hric_pkg::SecW'(lock_ms / hric_pkg::MS_PER_SEC);
    s.last_on = (rly == hric_pkg::RLY_NONE) ? '0 : on_stamp[rly];
    pending_status.push_back(s);
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one command word, idling first at random, and hold it until taken
  task automatic send_cmd(input hric_pkg::op_e op, input hric_pkg::relay_e rly);
    @(negedge clk);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    relay_type <= rly;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_status(op, rly);
  endtask

  task automatic cfg_write(input logic [hric_pkg::CfgIdxW-1:0] idx,
                           input logic [hric_pkg::LockW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == hric_pkg::CFG_COOL_DELAY)      cool_delay = val;
    else if (idx == hric_pkg::CFG_HEAT_DELAY) heat_delay = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every outstanding status word
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic tick_until_clear();
    while (lock_ms != '0)
      send_cmd(hric_pkg::OP_TICK, hric_pkg::relay_e'($urandom_range(3)));
  endtask

  function automatic hric_pkg::relay_e pick_relay();
    if ($urandom_range(99) < 5) return hric_pkg::RLY_NONE;
    return hric_pkg::relay_e'($urandom_range(2));
  endfunction

  function automatic hric_pkg::op_e pick_op();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 35) return hric_pkg::OP_TICK;
    if (k < 70) return hric_pkg::OP_ON;
    if (k < 90) return hric_pkg::OP_OFF;
    return hric_pkg::OP_ALL_OFF;
  endfunction

  // Random commands; lean on ticks while a lockout runs so it expires
  task automatic run_random(input int unsigned n);
    repeat (n) begin
      if (lock_ms != '0 && $urandom_range(99) < 60) send_cmd(hric_pkg::OP_TICK, pick_relay());
      else send_cmd(pick_op(), pick_relay());
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, plus long hold-offs on request
  // ---------------------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_stall  <= 1'b1;
        stall_hold = stall_hold - 1;
      end else begin
        out_stall <= ($urandom_range(99) < snk_idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each taken status word with the oldest prediction
  always @(posedge clk) begin
    status_t s;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: status word with none expected, expected none, actual %0d",
                   $time, action);
      end else begin
        s = pending_status.pop_front();
        check_field("accepted", s.accepted, accepted);
        check_field("heat_on", s.heat_on, heat_on);
        check_field("cool_on", s.cool_on, cool_on);
        check_field("fan_on", s.fan_on, fan_on);
        check_field("action", s.action, action);
        check_field("wait_seconds_left", s.secs, wait_secs);
        check_field("last_on_time", s.last_on, last_on_time);
      end
    end
  end

  // Bound the run
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset stamps, refusals in the startup lockout, then count it down
  task automatic test_startup_lockout();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_NONE);
    send_cmd(hric_pkg::OP_ALL_OFF, hric_pkg::RLY_FAN);
    tick_until_clear();
    drain();
  endtask

  // Interlocks, fan coupling, all off and the relay-three cases
  task automatic test_interlocks();
    cfg_write(hric_pkg::CFG_COOL_DELAY, 24'd2);
    cfg_write(hric_pkg::CFG_HEAT_DELAY, 24'd1);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_HEAT);
    tick_until_clear();
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    tick_until_clear();
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_FAN);
    tick_until_clear();
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_FAN);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_FAN);
    send_cmd(hric_pkg::OP_ALL_OFF, hric_pkg::RLY_FAN);
    tick_until_clear();
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_ALL_OFF, hric_pkg::RLY_NONE);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_NONE);
    send_cmd(hric_pkg::OP_TICK, hric_pkg::RLY_NONE);
    tick_until_clear();
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_NONE);
    drain();
  endtask

  // Zero heat delay: switching off starts no lockout
  task automatic test_zero_delay();
    cfg_write(hric_pkg::CFG_HEAT_DELAY, '0);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_ALL_OFF, hric_pkg::RLY_HEAT);
    drain();
  endtask

  task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct,
                                   input logic [hric_pkg::LockW-1:0] cool_ms,
                                   input logic [hric_pkg::LockW-1:0] heat_ms,
                                   input int unsigned n);
    cfg_write(hric_pkg::CFG_COOL_DELAY, cool_ms);
    cfg_write(hric_pkg::CFG_HEAT_DELAY, heat_ms);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    run_random(n);
    drain();
  endtask

  // Hold the receiver off while words keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    stall_hold   = 80;
    run_random(40);
    drain();
  endtask

  // Largest delays, an unused register index, and the longest lockout
  task automatic test_long_lockout();
    src_idle_pct = 0;
    snk_idle_pct = 30;
    send_cmd(hric_pkg::OP_ALL_OFF, hric_pkg::RLY_COOL);
    tick_until_clear();
    drain();
    cfg_write(hric_pkg::CFG_COOL_DELAY, DelayMax);
    cfg_write(hric_pkg::CFG_HEAT_DELAY, DelayMax);
    cfg_write(CfgIdxUnused, '0);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_HEAT);
    send_cmd(hric_pkg::OP_OFF, hric_pkg::RLY_HEAT);
    repeat (5) send_cmd(hric_pkg::OP_TICK, pick_relay());
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_COOL);
    send_cmd(hric_pkg::OP_ON, hric_pkg::RLY_FAN);
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    opcode     = hric_pkg::OP_TICK;
    relay_type = hric_pkg::RLY_HEAT;
    cfg_valid  = 1'b0;
    cfg_index  = hric_pkg::CFG_COOL_DELAY;
    cfg_data   = '0;
    mismatches = 0;
    stall_hold = 0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    relay_on   = '0;
    lock_ms    = hric_pkg::STARTUP_WAIT_MS;
    now_ms     = '0;
    on_stamp[hric_pkg::RLY_HEAT] = hric_pkg::HEAT_STAMP_RESET;
    on_stamp[hric_pkg::RLY_COOL] = '0;
    on_stamp[hric_pkg::RLY_FAN]  = '0;
    cool_delay = hric_pkg::COOL_DELAY_RESET;
    heat_delay = hric_pkg::HEAT_DELAY_RESET;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_startup_lockout();
    test_interlocks();
    test_zero_delay();
    test_random_phase(13, 68, hric_pkg::LockW'($urandom_range(40, 1)),
                      hric_pkg::LockW'($urandom_range(20)), 450);
    test_backpressure();
    test_random_phase(68, 13, '0, hric_pkg::LockW'($urandom_range(30, 1)), 450);
    test_random_phase(0, 0, hric_pkg::LockW'($urandom_range(60, 1)),
                      hric_pkg::LockW'($urandom_range(60, 1)), 400);
    test_long_lockout();

    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hric_pkg.sv
hw/rtl/hric_core.sv
hw/rtl/hric_div.sv
hw/rtl/hvac_relay_interlock_controller.sv
hw/rtl/hric_checker.sv
test/tb.sv
